>>> rtl/core/pls_pkg.sv
// Package for the positional list store: sizes, operation and status codes,
// and the control word broadcast to the row of cells. No dependencies.
`default_nettype none

package pls_pkg;

  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int POS_W      = 7;
  localparam int CMP_W      = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [2:0] {
    KIND_INS_FRONT = 3'd0,
    KIND_INS_BACK  = 3'd1,
    KIND_INS_AT    = 3'd2,
    KIND_DEL_FRONT = 3'd3,
    KIND_DEL_BACK  = 3'd4,
    KIND_DEL_AT    = 3'd5,
    KIND_READ_AT   = 3'd6,
    KIND_NOP       = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef struct packed {
    logic                  ins;
    logic                  del;
    logic [IDX_W-1:0]      idx;
    logic [DATA_WIDTH-1:0] val;
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> rtl/core/pls_cell.sv
// One entry of the shifting list: holds a value, takes the left neighbor on
// an insert below it, the right neighbor on a delete at or below it.
// Depends on pls_pkg.
`default_nettype none

module pls_cell
  import pls_pkg::*;
(
  input  wire logic                  clk,
  input  wire cell_ctl_t             ctl,
  input  wire logic [IDX_W-1:0]      here,
  input  wire logic [DATA_WIDTH-1:0] left,
  input  wire logic [DATA_WIDTH-1:0] right,
  output logic      [DATA_WIDTH-1:0] q,
  output logic      [DATA_WIDTH-1:0] sel
);

  logic                  at;
  logic                  after;
  logic [DATA_WIDTH-1:0] q_next;

  assign at    = (here == ctl.idx);
  assign after = (here > ctl.idx);
  assign sel   = at ? q : '0;

  always_comb begin
    q_next = q;
    if (ctl.ins) begin
      if (at) q_next = ctl.val;
      else if (after) q_next = left;
    end else if (ctl.del) begin
      if (at || after) q_next = right;
    end
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

`default_nettype wire

>>> rtl/core/positional_list_store_unit.sv
// Positional list store: top level with operation decode, row of cells and
// result register. Depends on pls_pkg and pls_cell.
//
// An ordered list of up to CAPACITY values held in a row of cells. On an
// insert (front/back/at) or delete (front/back/at) the row shifts up or down
// by one place; on a delete or a read (read at) the read or deleted value
// is picked from the cell that the position names. One
// result word comes back per input word, through a single output register;
// a new input word is taken whenever that register is empty or is being
// drained, so the throughput is one word per cycle while out_stall is low.
// Positions are 1-based; bad positions, inserts into a full list and
// deletes or reads on an empty list leave the list unchanged and are
// flagged in status.
`default_nettype none

module positional_list_store_unit
  import pls_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [2:0]        kind,
  input  wire logic [POS_W-1:0]  position,
  input  wire logic [31:0]       value,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             status,
  output logic [6:0]             count,
  output logic [31:0]            data_out
);

  logic [CNT_W-1:0]      cnt;
  logic [CNT_W-1:0]      cnt_next;
  logic                  accept;
  kind_t                 op;
  logic [CMP_W-1:0]      pos_x;
  logic [CMP_W-1:0]      cnt_x;
  logic                  full;
  logic                  empty;
  status_t               st;
  logic                  rd;
  logic [IDX_W-1:0]      idx;
  cell_ctl_t             ctl;
  logic [DATA_WIDTH+31:0] val_ext;
  logic [DATA_WIDTH+31:0] rd_ext;
  logic [DATA_WIDTH-1:0] rd_data;
  logic [CNT_W+6:0]      cnt_ext;

  logic [DATA_WIDTH-1:0] cell_q   [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_sel [CAPACITY];

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign op       = kind_t'(kind);
  assign pos_x    = CMP_W'(position);
  assign cnt_x    = CMP_W'(cnt);
  assign full     = (cnt == CNT_W'(CAPACITY));
  assign empty    = (cnt == '0);
  assign val_ext  = {{DATA_WIDTH{1'b0}}, value};

  // decode
  always_comb begin
    st      = ST_DONE;
    rd      = 1'b0;
    idx     = '0;
    ctl.ins = 1'b0;
    ctl.del = 1'b0;
    ctl.val = val_ext[DATA_WIDTH-1:0];
    unique case (op)
      KIND_INS_FRONT, KIND_INS_BACK, KIND_INS_AT: begin
        if (full) begin
          st = ST_FULL;
        end else if (op == KIND_INS_FRONT) begin
          ctl.ins = 1'b1;
        end else if (op == KIND_INS_BACK) begin
          ctl.ins = 1'b1;
          idx     = cnt[IDX_W-1:0];
        end else if (pos_x == '0 || pos_x > cnt_x + CMP_W'(1)) begin
          st = ST_BADPOS;
        end else begin
          ctl.ins = 1'b1;
          idx     = IDX_W'(pos_x - CMP_W'(1));
        end
      end
      KIND_DEL_FRONT, KIND_DEL_BACK, KIND_DEL_AT, KIND_READ_AT: begin
        if (empty) begin
          st = ST_EMPTY;
        end else if (op == KIND_DEL_FRONT) begin
          ctl.del = 1'b1;
          rd      = 1'b1;
        end else if (op == KIND_DEL_BACK) begin
          ctl.del = 1'b1;
          rd      = 1'b1;
          idx     = IDX_W'(cnt_x - CMP_W'(1));
        end else if (pos_x == '0 || pos_x > cnt_x) begin
          st = ST_BADPOS;
        end else begin
          ctl.del = (op == KIND_DEL_AT);
          rd      = 1'b1;
          idx     = IDX_W'(pos_x - CMP_W'(1));
        end
      end
      default: begin
        st = ST_DONE;
      end
    endcase
    ctl.idx = idx;
    if (!accept) begin
      ctl.ins = 1'b0;
      ctl.del = 1'b0;
    end
  end

  always_comb begin
    cnt_next = cnt;
    if (ctl.ins) cnt_next = cnt + CNT_W'(1);
    else if (ctl.del) cnt_next = cnt - CNT_W'(1);
  end

  // row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left;
    logic [DATA_WIDTH-1:0] right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_q[i+1];
    end
    pls_cell u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .here  (IDX_W'(i)),
      .left  (left),
      .right (right),
      .q     (cell_q[i]),
      .sel   (cell_sel[i])
    );
  end

  always_comb begin
    rd_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_data = rd_data | cell_sel[i];
    end
  end

  assign rd_ext  = {32'b0, (rd ? rd_data : {DATA_WIDTH{1'b0}})};
  assign cnt_ext = {7'b0, cnt_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      cnt <= cnt_next;
      if (accept) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status   <= st;
      count    <= cnt_ext[6:0];
      data_out <= rd_ext[31:0];
    end
  end

endmodule

`default_nettype wire
